// File: sv/lpjs_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the lifo preemptive job scheduler
// no dependencies; imported by every module of the block

package lpjs_pkg;

    localparam int STACK_DEPTH_DEF = 64;
    localparam int SVC_W           = 8;
    localparam int TICK_W          = 32;
    localparam int CNT_W           = 32;
    localparam int SUM_W           = 64;
    localparam int IN_TDATA_W      = 16;
    localparam int OUT_TDATA_W     = 136;

    // one stacked job: remaining service and arrival tick plus length
    typedef struct packed {
        logic [SVC_W-1:0]  rem;
        logic [TICK_W-1:0] base;
    } t_entry;

    // broadcast shift control for the row of stack cells
    typedef struct packed {
        logic push;
        logic pop;
        logic dec;
    } t_shift_ctl;

endpackage

// File: sv/lpjs_cell.sv
`timescale 1ns / 1ps
// one stack cell: holds a job entry, loads from its upper or lower neighbor or counts down its remaining service
// depends on lpjs_pkg

module lpjs_cell (
    input  logic               i_clk,
    input  lpjs_pkg::t_shift_ctl i_ctl,
    input  lpjs_pkg::t_entry   i_above,
    input  lpjs_pkg::t_entry   i_below,
    output lpjs_pkg::t_entry   o_entry
);
    import lpjs_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    always_comb begin
        n_entry = r_entry;
        priority if (i_ctl.push) begin
            n_entry = i_above;
        end else if (i_ctl.pop) begin
            n_entry = i_below;
        end else if (i_ctl.dec) begin
            n_entry.rem = r_entry.rem - SVC_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

// File: sv/lpjs_accum.sv
`timescale 1ns / 1ps
// saturating running totals of completed jobs and of their waits
// depends on lpjs_pkg

module lpjs_accum (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  logic                        i_done,
    input  logic [lpjs_pkg::TICK_W-1:0] i_wait,
    output logic [lpjs_pkg::CNT_W-1:0]  o_done_total,
    output logic [lpjs_pkg::SUM_W-1:0]  o_wait_total
);
    import lpjs_pkg::*;

    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic [SUM_W-1:0] r_sum;
    logic [SUM_W-1:0] n_sum;
    logic [SUM_W:0]   w_sum_ext;

    assign w_sum_ext = {1'b0, r_sum} + {{(SUM_W-TICK_W+1){1'b0}}, i_wait};

    always_comb begin
        n_cnt = r_cnt;
        n_sum = r_sum;
        if (i_load && i_done) begin
            if (r_cnt != '1) begin
                n_cnt = r_cnt + CNT_W'(1);
            end
            n_sum = w_sum_ext[SUM_W] ? '1 : w_sum_ext[SUM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_sum <= '0;
        end else begin
            r_cnt <= n_cnt;
            r_sum <= n_sum;
        end
    end

    assign o_done_total = r_cnt;
    assign o_wait_total = r_sum;

    // totals never move backward
    a_cnt_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> r_cnt >= $past(r_cnt))
        else $error("completed count decreased");
    a_sum_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> r_sum >= $past(r_sum))
        else $error("wait sum decreased");
    a_sum_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_load && i_done) |=> $stable(r_sum) && $stable(r_cnt))
        else $error("totals changed without a completed job");

endmodule

// File: sv/lifo_preemptive_job_scheduler.sv
`timescale 1ns / 1ps
// lifo preemptive job scheduler, one input transaction per tick, one result each
// each result passes the stage 1 register and then the output register before it is offered
// throughput: 1 tick per cycle while i_m_tready does not hold the output, set by the push/serve/pop at cell 0
// reset (sync, active low) clears tick, depth, totals and valids; cells keep data
// depends on lpjs_pkg, lpjs_cell, lpjs_accum

module lifo_preemptive_job_scheduler #(
    parameter int STACK_DEPTH = lpjs_pkg::STACK_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input fields from bit 0: job_arrives[0], service_ticks[8:1], zero pad
    input  logic [lpjs_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // result fields from bit 0: job_done[0], job_wait[32:1], idle_tick[33],
    // arrival_dropped[34], done_total[66:35], wait_total[130:67], zero pad
    output logic [lpjs_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready
);
    import lpjs_pkg::*;

    localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);

    // ---------------- input transaction decode ----------------
    logic              w_acc;
    logic              w_arrives;
    logic [SVC_W-1:0]  w_len;
    logic              w_full;
    logic              w_push;
    logic              w_dropped;

    // ---------------- stack control ----------------
    logic [TICK_W-1:0]  r_tick;
    logic [TICK_W-1:0]  n_tick;
    logic [DEPTH_W-1:0] r_depth;
    logic [DEPTH_W-1:0] n_depth;
    t_entry             w_top;
    t_entry             w_new;
    logic               w_busy;
    logic [SVC_W-1:0]   w_rem_dec;
    logic               w_done;
    logic [TICK_W-1:0]  w_wait;
    t_shift_ctl         w_ctl;
    t_entry             w_cell [STACK_DEPTH];

    // ---------------- pipeline registers ----------------
    logic              r_s1_valid;
    logic              r_s1_done;
    logic [TICK_W-1:0] r_s1_wait;
    logic              r_s1_idle;
    logic              r_s1_drop;
    logic              r_out_valid;
    logic              r_out_done;
    logic [TICK_W-1:0] r_out_wait;
    logic              r_out_idle;
    logic              r_out_drop;
    logic              w_out_free;
    logic [CNT_W-1:0]  w_done_total;
    logic [SUM_W-1:0]  w_wait_total;

    // output stage frees when empty or taken; stage 1 moves on then
    assign w_out_free = !r_out_valid || i_m_tready;
    assign o_s_tready = !r_s1_valid || w_out_free;
    assign w_acc      = i_s_tvalid && o_s_tready;

    assign w_arrives  = i_s_tdata[0];
    // a zero service length counts as one tick
    assign w_len      = (i_s_tdata[SVC_W:1] == '0) ? SVC_W'(1) : i_s_tdata[SVC_W:1];
    assign w_full     = (r_depth == DEPTH_W'(STACK_DEPTH));
    assign w_push     = w_arrives && !w_full;
    assign w_dropped  = w_arrives && w_full;

    // top of stack after a possible push; base is arrival tick plus length
    always_comb begin
        w_new.rem  = w_len;
        w_new.base = r_tick + {{(TICK_W-SVC_W){1'b0}}, w_len};
        w_top      = w_push ? w_new : w_cell[0];
    end

    assign n_tick    = r_tick + TICK_W'(1);
    assign w_busy    = w_push || (r_depth != '0);
    assign w_rem_dec = w_top.rem - SVC_W'(1);
    assign w_done    = w_busy && (w_rem_dec == '0);
    // wait = tick after advance - length - arrival
    assign w_wait    = n_tick - w_top.base;

    // push and finish in the same tick leaves the row untouched
    always_comb begin
        w_ctl.push = w_acc && w_push && !w_done;
        w_ctl.pop  = w_acc && !w_push && w_done;
        w_ctl.dec  = w_acc && !w_push && w_busy && !w_done;
    end

    always_comb begin
        n_depth = r_depth;
        if (w_ctl.push) begin
            n_depth = r_depth + DEPTH_W'(1);
        end else if (w_ctl.pop) begin
            n_depth = r_depth - DEPTH_W'(1);
        end
    end

    // row of cells, cell 0 is the top of the stack
    for (genvar gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
        t_shift_ctl w_cell_ctl;
        t_entry     w_above;
        t_entry     w_below;

        always_comb begin
            w_cell_ctl      = w_ctl;
            w_cell_ctl.dec  = (gi == 0) ? w_ctl.dec : 1'b0;
        end

        if (gi == 0) begin : g_top
            // new job enters with this tick's service already taken
            always_comb begin
                w_above      = w_new;
                w_above.rem  = w_rem_dec;
            end
        end else begin : g_mid
            assign w_above = w_cell[gi-1];
        end

        if (gi == STACK_DEPTH - 1) begin : g_last
            assign w_below = '0;
        end else begin : g_inner
            assign w_below = w_cell[gi+1];
        end

        lpjs_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_cell_ctl),
            .i_above (w_above),
            .i_below (w_below),
            .o_entry (w_cell[gi])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick  <= '0;
            r_depth <= '0;
        end else if (w_acc) begin
            r_tick  <= n_tick;
            r_depth <= n_depth;
        end
    end

    // stage 1: per-tick flags and wait
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_s1_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1_done <= w_done;
            r_s1_wait <= w_done ? w_wait : '0;
            r_s1_idle <= !w_busy;
            r_s1_drop <= w_dropped;
        end
    end

    // stage 2: output register, totals updated alongside
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && r_s1_valid) begin
            r_out_done <= r_s1_done;
            r_out_wait <= r_s1_wait;
            r_out_idle <= r_s1_idle;
            r_out_drop <= r_s1_drop;
        end
    end

    lpjs_accum u_accum (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (w_out_free && r_s1_valid),
        .i_done       (r_s1_done),
        .i_wait       (r_s1_wait),
        .o_done_total (w_done_total),
        .o_wait_total (w_wait_total)
    );

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_TDATA_W-SUM_W-CNT_W-TICK_W-3){1'b0}},
                         w_wait_total, w_done_total,
                         r_out_drop, r_out_idle, r_out_wait, r_out_done};

    // stack occupancy stays within the row
    a_depth_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DEPTH_W'(STACK_DEPTH))
        else $error("stack depth beyond capacity");
    // a dropped arrival never grows the stack
    a_drop_no_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_dropped) |=> r_depth <= $past(r_depth))
        else $error("stack grew on a dropped arrival");
    // an idle tick finishes no job
    a_idle_no_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> !(r_s1_idle && r_s1_done))
        else $error("job finished on an idle tick");
    // the tick counter advances only with an input transaction
    a_tick_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_acc |=> $stable(r_tick) && $stable(r_depth))
        else $error("stack state changed without a transaction");

endmodule
